// ===== hw/rtl/bcd_pkg.sv =====
// shared types and constants of the button click, double click and long press classifier
package bcd_pkg;

	typedef logic [1:0] act_t;

	localparam act_t ACT_CLICK  = 2'd0;
	localparam act_t ACT_DOUBLE = 2'd1;
	localparam act_t ACT_LONG   = 2'd2;

	typedef logic [1:0] reg_idx_t;

	localparam reg_idx_t REG_DEBOUNCE = 2'd0;
	localparam reg_idx_t REG_LONG     = 2'd1;
	localparam reg_idx_t REG_GAP      = 2'd2;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [15:0] DEBOUNCE_RST = 16'd30;
	localparam logic [15:0] LONG_RST     = 16'd800;
	localparam logic [15:0] GAP_RST      = 16'd300;

	typedef struct packed {
		logic [15:0] debounce_ms;
		logic [15:0] long_press_ms;
		logic [15:0] double_gap_ms;
	} cfg_t;

	typedef struct packed {
		logic have;
		act_t act;
	} ev_t;

endpackage

// ===== hw/rtl/bcd_button.sv =====
// per-button debounce and click, double click and long press state
module bcd_button import bcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        raw_pressed,
	input  logic [31:0] now_ms,
	input  cfg_t        cfg,
	output ev_t         ev
);

	logic        pressed_q;
	logic        long_q;
	logic        pending_q;
	logic        armed_q;
	logic [31:0] edge_time_q;
	logic [31:0] rel_time_q;

	logic        pressed_d;
	logic        long_d;
	logic        pending_d;
	logic        armed_d;
	logic [31:0] edge_time_d;
	logic [31:0] rel_time_d;

	logic [31:0] edge_el;
	logic [31:0] rel_el;
	logic [31:0] hold_el;
	logic [31:0] wait_el;
	logic        take_edge;
	logic        new_rel;

	assign edge_el   = now_ms - edge_time_q;
	assign rel_el    = now_ms - rel_time_q;
	assign take_edge = (raw_pressed != pressed_q) && (edge_el >= {16'b0, cfg.debounce_ms});

	always_comb begin
		pressed_d   = pressed_q;
		long_d      = long_q;
		pending_d   = pending_q;
		armed_d     = armed_q;
		edge_time_d = edge_time_q;
		rel_time_d  = rel_time_q;
		new_rel     = 1'b0;
		ev.have     = 1'b0;
		ev.act      = ACT_CLICK;
		if (take_edge) begin
			pressed_d   = raw_pressed;
			edge_time_d = now_ms;
			if (raw_pressed) begin
				long_d = 1'b0;
				if (pending_q && (rel_el <= {16'b0, cfg.double_gap_ms})) begin
					pending_d = 1'b0;
					armed_d   = 1'b1;
				end
			end else if (long_q) begin
				pending_d = 1'b0;
				armed_d   = 1'b0;
			end else if (armed_q) begin
				armed_d = 1'b0;
				ev.have = 1'b1;
				ev.act  = ACT_DOUBLE;
			end else begin
				pending_d  = 1'b1;
				rel_time_d = now_ms;
				new_rel    = 1'b1;
			end
		end
		hold_el = take_edge ? 32'd0 : edge_el;
		wait_el = new_rel ? 32'd0 : rel_el;
		if (!ev.have && pressed_d && !long_d && (hold_el >= {16'b0, cfg.long_press_ms})) begin
			long_d    = 1'b1;
			pending_d = 1'b0;
			armed_d   = 1'b0;
			ev.have   = 1'b1;
			ev.act    = ACT_LONG;
		end
		if (!ev.have && !pressed_d && pending_d && (wait_el > {16'b0, cfg.double_gap_ms})) begin
			pending_d = 1'b0;
			ev.have   = 1'b1;
			ev.act    = ACT_CLICK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_q   <= 1'b0;
			long_q      <= 1'b0;
			pending_q   <= 1'b0;
			armed_q     <= 1'b0;
			edge_time_q <= 32'd0;
			rel_time_q  <= 32'd0;
		end else if (en) begin
			pressed_q   <= pressed_d;
			long_q      <= long_d;
			pending_q   <= pending_d;
			armed_q     <= armed_d;
			edge_time_q <= edge_time_d;
			rel_time_q  <= rel_time_d;
		end
	end

endmodule

// ===== hw/rtl/button_click_double_long_classifier.sv =====
// top level of the button click, double click and long press classifier
// path: the first event of a poll goes from the input register through the event buffer to the output register
// throughput: one poll per cycle while polls give no event; a poll with events holds the event
// buffer until its last event is loaded, since the output register sends one event per cycle while m_tready is high
// reset: all per-button state cleared, registers back to 30, 800 and 300 ms
module button_click_double_long_classifier import bcd_pkg::*; #(
	parameter  int BUTTON_COUNT = 2,
	localparam int IDX_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1,
	localparam int IN_W  = ((BUTTON_COUNT + 32 + 7) / 8) * 8,
	localparam int OUT_W = ((IDX_W + 2 + 7) / 8) * 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [IN_W-1:0]    s_tdata,   // pin_levels, now_ms
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [OUT_W-1:0]   m_tdata,   // button_index, action
	output logic               m_tlast,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	cfg_t                    cfg_q;
	reg_idx_t                reg_idx;

	logic                    valid_s1;
	logic [BUTTON_COUNT-1:0] levels_s1;
	logic [31:0]             now_s1;

	ev_t                     ev     [BUTTON_COUNT];
	logic [BUTTON_COUNT-1:0] ev_mask_q;
	act_t                    ev_act_q [BUTTON_COUNT];

	logic                    out_valid_q;
	logic [IDX_W-1:0]        out_idx_q;
	act_t                    out_act_q;
	logic                    out_last_q;

	logic                    load_out;
	logic [IDX_W-1:0]        pick;
	logic [BUTTON_COUNT-1:0] rest_mask;
	logic                    buf_free;
	logic                    advance;

	// configuration port
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];

	always_comb begin
		unique case (reg_idx)
			REG_DEBOUNCE: prdata = {16'b0, cfg_q.debounce_ms};
			REG_LONG:     prdata = {16'b0, cfg_q.long_press_ms};
			REG_GAP:      prdata = {16'b0, cfg_q.double_gap_ms};
			default:      prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms   <= DEBOUNCE_RST;
			cfg_q.long_press_ms <= LONG_RST;
			cfg_q.double_gap_ms <= GAP_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				REG_DEBOUNCE: cfg_q.debounce_ms   <= pwdata[15:0];
				REG_LONG:     cfg_q.long_press_ms <= pwdata[15:0];
				REG_GAP:      cfg_q.double_gap_ms <= pwdata[15:0];
				default:      ;
			endcase
		end
	end

	// event buffer pop, lowest button first
	always_comb begin
		pick = '0;
		for (int i = BUTTON_COUNT - 1; i >= 0; i--) begin
			if (ev_mask_q[i]) begin
				pick = IDX_W'(i);
			end
		end
	end

	assign load_out  = (ev_mask_q != '0) && (!out_valid_q || m_tready);
	assign rest_mask = ev_mask_q & ~(BUTTON_COUNT'(1) << pick);
	assign buf_free  = load_out ? (rest_mask == '0) : (ev_mask_q == '0);
	assign advance   = valid_s1 && buf_free;
	assign s_tready  = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			levels_s1 <= s_tdata[BUTTON_COUNT-1:0];
			now_s1    <= s_tdata[BUTTON_COUNT+31:BUTTON_COUNT];
		end
	end

	for (genvar b = 0; b < BUTTON_COUNT; b++) begin : g_btn
		bcd_button u_btn (
			.clk         (clk),
			.arst_n      (arst_n),
			.en          (advance),
			.raw_pressed (!levels_s1[b]),
			.now_ms      (now_s1),
			.cfg         (cfg_q),
			.ev          (ev[b])
		);
	end

	// event buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_mask_q <= '0;
		end else if (advance) begin
			for (int i = 0; i < BUTTON_COUNT; i++) begin
				ev_mask_q[i] <= ev[i].have;
			end
		end else if (load_out) begin
			ev_mask_q <= rest_mask;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < BUTTON_COUNT; i++) begin
				ev_act_q[i] <= ev[i].act;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_idx_q  <= pick;
			out_act_q  <= ev_act_q[pick];
			out_last_q <= (rest_mask == '0);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'({out_act_q, out_idx_q});
	assign m_tlast  = out_last_q;

endmodule

// ===== hw/rtl/bcd_checker.sv =====
// port checks for the button classifier, bound to the top level
module bcd_checker import bcd_pkg::*; #(
	parameter  int BUTTON_COUNT = 2,
	localparam int IDX_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1,
	localparam int IN_W  = ((BUTTON_COUNT + 32 + 7) / 8) * 8,
	localparam int OUT_W = ((IDX_W + 2 + 7) / 8) * 8
) (
	input logic               clk,
	input logic               arst_n,
	input logic               s_tvalid,
	input logic               s_tready,
	input logic [IN_W-1:0]    s_tdata,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [OUT_W-1:0]   m_tdata,
	input logic               m_tlast,
	input logic               psel,
	input logic               penable,
	input logic               pwrite,
	input logic [PADDR_W-1:0] paddr,
	input logic [PDATA_W-1:0] pwdata,
	input logic [PDATA_W-1:0] prdata,
	input logic               pready
);

	// stalled item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output item changed while stalled");

	// only click, double or long
	a_act_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[IDX_W+1:IDX_W] != 2'd3)
		else $error("undefined action code");

	// no item out of reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("output valid during reset");

	// padding stays zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_W-1:IDX_W+2] == '0)
		else $error("tdata padding not zero");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind button_click_double_long_classifier bcd_checker #(.BUTTON_COUNT(BUTTON_COUNT)) u_bcd_checker (.*);

// ===== tb/tb_top.sv =====
// self-checking testbench of the button click, double click and long press classifier
module tb_top import bcd_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int BUTTONS = 2;
	localparam int IN_W    = 40;
	localparam int OUT_W   = 8;
	localparam int SETTLE  = 8;

	typedef struct {
		logic [1:0]  pins;
		logic [31:0] stamp;
	} poll_t;

	typedef struct {
		logic btn;
		act_t act;
		logic tail;
	} press_event_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [IN_W-1:0]    s_tdata = '0;   // pin_levels, now_ms
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [OUT_W-1:0]   m_tdata;        // button_index, action
	logic               m_tlast;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	poll_t        pending_polls[$];
	press_event_t event_q[$];

	// predictor copy of the registers and per-button state
	logic [15:0] deb_ms, long_ms, gap_ms;
	logic        held[BUTTONS];
	logic        long_done[BUTTONS];
	logic        click_wait[BUTTONS];
	logic        armed[BUTTONS];
	logic [31:0] edge_at[BUTTONS];
	logic [31:0] rel_at[BUTTONS];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatches = 0;
	int polls_taken = 0;
	int events_seen = 0;
	int settings_used = 1;
	logic [1:0]  cur_pins = 2'b11;
	logic [31:0] clock_ms = '0;

	button_click_double_long_classifier u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #5 clk = ~clk;

	task automatic report(input string what);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch at %0t: %s", $realtime, what);
	endtask

	task automatic classify_poll(input logic [1:0] pins, input logic [31:0] stamp);
		logic raw, have;
		act_t act;
		int prior_cnt;
		press_event_t ev;
		prior_cnt = event_q.size();
		for (int b = 0; b < BUTTONS; b++) begin
			raw = !pins[b];
			have = 1'b0;
			act = ACT_CLICK;
			if (raw != held[b] && (stamp - edge_at[b]) >= deb_ms) begin
				held[b] = raw;
				edge_at[b] = stamp;
				if (raw) begin
					long_done[b] = 1'b0;
					if (click_wait[b] && (stamp - rel_at[b]) <= gap_ms) begin
						click_wait[b] = 1'b0;
						armed[b] = 1'b1;
					end
				end else if (long_done[b]) begin
					click_wait[b] = 1'b0;
					armed[b] = 1'b0;
				end else if (armed[b]) begin
					armed[b] = 1'b0;
					have = 1'b1;
					act = ACT_DOUBLE;
				end else begin
					click_wait[b] = 1'b1;
					rel_at[b] = stamp;
				end
			end
			if (!have && held[b] && !long_done[b] && (stamp - edge_at[b]) >= long_ms) begin
				long_done[b] = 1'b1;
				click_wait[b] = 1'b0;
				armed[b] = 1'b0;
				have = 1'b1;
				act = ACT_LONG;
			end
			if (!have && !held[b] && click_wait[b] && (stamp - rel_at[b]) > gap_ms) begin
				click_wait[b] = 1'b0;
				have = 1'b1;
				act = ACT_CLICK;
			end
			if (have) begin
				ev.btn = b[0];
				ev.act = act;
				ev.tail = 1'b0;
				event_q.push_back(ev);
			end
		end
		if (event_q.size() > prior_cnt)
			event_q[event_q.size()-1].tail = 1'b1;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin : drv
		poll_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (pending_polls.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = pending_polls.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {6'b0, nxt.stamp, nxt.pins};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// monitor and checker
	always @(posedge clk) begin : mon
		press_event_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				polls_taken++;
				classify_poll(s_tdata[1:0], s_tdata[33:2]);
			end
			if (m_tvalid && m_tready) begin
				events_seen++;
				if (event_q.size() == 0) begin
					report($sformatf("unexpected event button %0d action %0d last %0d",
						m_tdata[0], m_tdata[2:1], m_tlast));
				end else begin
					want = event_q.pop_front();
					if (m_tdata[0] !== want.btn || m_tdata[2:1] !== want.act ||
							m_tlast !== want.tail)
						report($sformatf("expected button %0d action %0d last %0d, got %0d %0d %0d",
							want.btn, want.act, want.tail, m_tdata[0], m_tdata[2:1], m_tlast));
				end
			end
		end
	end

	task automatic reg_access(input reg_idx_t idx, input logic wr, input logic [15:0] val,
			output logic [PDATA_W-1:0] rd);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= {16'b0, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_reg(input reg_idx_t idx, input logic [15:0] val);
		logic [PDATA_W-1:0] rd;
		reg_access(idx, 1'b1, val, rd);
		case (idx)
			REG_DEBOUNCE: deb_ms = val;
			REG_LONG:     long_ms = val;
			REG_GAP:      gap_ms = val;
			default: ;
		endcase
		reg_access(idx, 1'b0, 16'd0, rd);
		if (rd !== {16'b0, val})
			report($sformatf("register %0d read expected %0d, got %0d", idx, val, rd));
	endtask

	task automatic add_poll(input logic [1:0] pins, input logic [31:0] stamp);
		poll_t p;
		p.pins = pins;
		p.stamp = stamp;
		pending_polls.push_back(p);
	endtask

	task automatic drain();
		@(negedge clk);
		while (pending_polls.size() != 0 || s_tvalid || event_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	function automatic logic [31:0] pick_step();
		case ($urandom_range(9))
			0: return $urandom_range(3);
			1: return 32'(deb_ms) - 1 + $urandom_range(2);
			2: return 32'(gap_ms) - 1 + $urandom_range(2);
			3: return 32'(long_ms) - 1 + $urandom_range(2);
			4: return $urandom_range(gap_ms);
			5: return $urandom_range(32'(long_ms) + deb_ms);
			6: return 32'(deb_ms) + $urandom_range(gap_ms);
			7: return 32'hFFFF_FFFF - $urandom_range(50);
			default: return $urandom_range(200);
		endcase
	endfunction

	int cfg_table[6][3] = '{
		'{30, 800, 300}, '{0, 0, 0}, '{5, 60, 40},
		'{65535, 65535, 65535}, '{0, 1, 65535}, '{200, 50, 1}
	};

	initial begin
		deb_ms = DEBOUNCE_RST;
		long_ms = LONG_RST;
		gap_ms = GAP_RST;
		for (int b = 0; b < BUTTONS; b++) begin
			held[b] = 1'b0;
			long_done[b] = 1'b0;
			click_wait[b] = 1'b0;
			armed[b] = 1'b0;
			edge_at[b] = '0;
			rel_at[b] = '0;
		end
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed gestures under the reset register values
		add_poll(2'b11, 32'd0);
		add_poll(2'b10, 32'd100);
		add_poll(2'b11, 32'd200);
		add_poll(2'b11, 32'd600);
		add_poll(2'b10, 32'd1000);
		add_poll(2'b10, 32'd1900);
		add_poll(2'b11, 32'd2000);
		add_poll(2'b10, 32'd3000);
		add_poll(2'b11, 32'd3100);
		add_poll(2'b10, 32'd3200);
		add_poll(2'b11, 32'd3300);
		add_poll(2'b00, 32'd4000);
		add_poll(2'b00, 32'd4900);
		add_poll(2'b11, 32'd5000);
		add_poll(2'b01, 32'd5010);
		add_poll(2'b01, 32'd5100);
		add_poll(2'b11, 32'd5200);
		add_poll(2'b01, 32'd5600);
		add_poll(2'b11, 32'd5700);
		add_poll(2'b11, 32'd6100);
		add_poll(2'b11, 32'hFFFF_FFFF);
		add_poll(2'b10, 32'd10);
		add_poll(2'b11, 32'd5);
		add_poll(2'b11, 32'd400);
		drain();
		clock_ms = 32'd400;

		for (int p = 0; p < 6; p++) begin
			set_reg(REG_DEBOUNCE, 16'(cfg_table[p][0]));
			set_reg(REG_LONG, 16'(cfg_table[p][1]));
			set_reg(REG_GAP, 16'(cfg_table[p][2]));
			settings_used++;
			@(negedge clk);
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
				default: begin send_idle_pct = 27; recv_stall_pct = 27; end
			endcase
			if (p == 3)
				clock_ms = 32'hFFFF_F000;
			for (int i = 0; i < 88; i++) begin
				if ($urandom_range(99) < 85) begin
					for (int b = 0; b < BUTTONS; b++)
						if ($urandom_range(99) < 40)
							cur_pins[b] = ~cur_pins[b];
					clock_ms = clock_ms + pick_step();
				end else begin
					cur_pins = 2'($urandom_range(3));
					clock_ms = $urandom();
				end
				add_poll(cur_pins, clock_ms);
			end
			drain();
		end

		repeat (20) @(posedge clk);
		$display("covered %0d polls under %0d register settings with varied idling",
			polls_taken, settings_used);
		$display("%0d events checked, %0d mismatches", events_seen, mismatches);
		if (mismatches == 0 && event_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#3000000;
		$display("timeout with %0d events outstanding", event_q.size());
		$display("Regression FAIL");
		$finish;
	end

endmodule
